// ===== rtl/uopd_pkg.sv =====
package uopd_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    localparam int MaxResults = 4 - 1;

    localparam logic [2:0] K_PATH_BYTE   = 3'd0;
    localparam logic [2:0] K_SEG_END     = 3'd1;
    localparam logic [2:0] K_QUERY_START = 3'd2;
    localparam logic [2:0] K_QUERY_BYTE  = 3'd3;
    localparam logic [2:0] K_ACCEPT      = 3'd4;
    localparam logic [2:0] K_ERROR       = 3'd5;

    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_BAD_PATH   = 3'd1;
    localparam logic [2:0] E_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] E_BAD_SEG    = 3'd3;
    localparam logic [2:0] E_BAD_QUERY  = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] error_code;
        logic       run_end;
    } res_t;

    typedef struct packed {
        logic [1:0]                  count;
        res_t [MaxResults-1:0]       res;
    } step_out_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_seg_char(input logic [7:0] c);
        logic ok;
        ok = is_alnum(c);
        unique case (c)
            8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28,
            8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h3A, 8'h40: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    function automatic logic is_query_char(input logic [7:0] c);
        return is_seg_char(c) || c == CH_SLASH || c == CH_QMARK || c == CH_PCT;
    endfunction

    // Returns {valid, value} for one hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== rtl/uopd_step.sv =====
module uopd_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [7:0]          byte_in,
    input  logic                final_byte,
    output uopd_pkg::step_out_t step_out
);
    import uopd_pkg::*;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_PATH  = 3'd1;
    localparam logic [2:0] PH_ESC1  = 3'd2;
    localparam logic [2:0] PH_ESC2  = 3'd3;
    localparam logic [2:0] PH_QUERY = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic       seg_bytes_reg, seg_bytes_next;
    logic       seg_done_reg, seg_done_next;
    logic [3:0] nibble_reg, nibble_next;

    logic [4:0] hex;
    logic [2:0] err;
    logic [1:0] n;
    logic       skip;
    res_t [MaxResults-1:0] res;

    always_comb begin
        hex            = hex_value(byte_in);
        err            = E_NONE;
        n              = 2'd0;
        skip           = 1'b0;
        res            = '0;
        phase_next     = phase_reg;
        seg_bytes_next = seg_bytes_reg;
        seg_done_next  = seg_done_reg;
        nibble_next    = nibble_reg;

        unique case (phase_reg)
            PH_PATH: begin
                if (byte_in == CH_SLASH) begin
                    if (seg_bytes_reg) begin
                        res[n].kind    = K_SEG_END;
                        n              = n + 2'd1;
                        seg_bytes_next = 1'b0;
                        seg_done_next  = 1'b1;
                    end else begin
                        err = E_BAD_PATH;
                    end
                end else if (byte_in == CH_PCT) begin
                    phase_next = PH_ESC1;
                end else if (byte_in == CH_QMARK) begin
                    if (seg_bytes_reg || seg_done_reg) begin
                        res[n].kind = K_SEG_END;
                        n           = n + 2'd1;
                    end
                    seg_bytes_next = 1'b0;
                    seg_done_next  = 1'b0;
                    res[n].kind    = K_QUERY_START;
                    n              = n + 2'd1;
                    phase_next     = PH_QUERY;
                end else if (is_seg_char(byte_in)) begin
                    res[n].kind    = K_PATH_BYTE;
                    res[n].data    = byte_in;
                    n              = n + 2'd1;
                    seg_bytes_next = 1'b1;
                end else begin
                    err = E_BAD_SEG;
                end
            end
            PH_ESC1: begin
                if (hex[4]) begin
                    nibble_next = hex[3:0];
                    phase_next  = PH_ESC2;
                end else begin
                    err = E_BAD_ESCAPE;
                end
            end
            PH_ESC2: begin
                if (hex[4]) begin
                    res[n].kind    = K_PATH_BYTE;
                    res[n].data    = {nibble_reg, hex[3:0]};
                    n              = n + 2'd1;
                    seg_bytes_next = 1'b1;
                    phase_next     = PH_PATH;
                end else begin
                    err = E_BAD_ESCAPE;
                end
            end
            PH_QUERY: begin
                if (is_query_char(byte_in)) begin
                    res[n].kind = K_QUERY_BYTE;
                    res[n].data = byte_in;
                    n           = n + 2'd1;
                end else begin
                    err = E_BAD_QUERY;
                end
            end
            PH_SKIP: begin
                skip = 1'b1;
            end
            default: begin
                if (byte_in == CH_SLASH) begin
                    phase_next = PH_PATH;
                end else begin
                    err = E_BAD_PATH;
                end
            end
        endcase

        // The final byte closes the path or query; ending anywhere else is a short escape.
        if (!skip && err == E_NONE && final_byte) begin
            if (phase_next == PH_PATH) begin
                if (seg_bytes_next || seg_done_next) begin
                    res[n].kind = K_SEG_END;
                    n           = n + 2'd1;
                end
                res[n].kind = K_ACCEPT;
                n           = n + 2'd1;
            end else if (phase_next == PH_QUERY) begin
                res[n].kind = K_ACCEPT;
                n           = n + 2'd1;
            end else begin
                err = E_BAD_ESCAPE;
            end
        end

        if (err != E_NONE) begin
            res                 = '0;
            res[0].kind         = K_ERROR;
            res[0].error_code   = err;
            n                   = 2'd1;
            phase_next          = PH_SKIP;
        end

        if (final_byte) begin
            phase_next     = PH_START;
            seg_bytes_next = 1'b0;
            seg_done_next  = 1'b0;
            nibble_next    = 4'd0;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].run_end = 1'b1;
        end

        step_out.count = n;
        step_out.res   = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            seg_bytes_reg <= 1'b0;
            seg_done_reg  <= 1'b0;
            nibble_reg    <= 4'd0;
        end else if (take) begin
            phase_reg     <= phase_next;
            seg_bytes_reg <= seg_bytes_next;
            seg_done_reg  <= seg_done_next;
            nibble_reg    <= nibble_next;
        end
    end

endmodule

// ===== rtl/uopd_obuf.sv =====
module uopd_obuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  uopd_pkg::step_out_t step_out,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output uopd_pkg::res_t      out_res
);
    import uopd_pkg::*;

    res_t       buf_reg [MaxResults];
    logic [1:0] count_reg, count_next;
    logic [1:0] rd_reg, rd_next;
    logic       pop;

    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_res   = buf_reg[rd_reg];

    // A new item may land when the buffer is empty or its last result leaves now.
    assign can_load  = count_reg == 2'd0 || (count_reg == 2'd1 && out_ready);

    always_comb begin
        count_next = count_reg;
        rd_next    = rd_reg;
        if (load) begin
            count_next = step_out.count;
            rd_next    = 2'd0;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
            rd_next    = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            rd_reg    <= 2'd0;
        end else begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MaxResults; i++) begin
                buf_reg[i] <= step_out.res[i];
            end
        end
    end

endmodule

// ===== rtl/uri_origin_path_decoder.sv =====
// Channel  Direction  tdata (low bit up)            tuser   tlast
// s_       in         byte_in[7:0]                  -       final_byte
// m_       out        data[7:0], error_code[10:8]   kind    run_end
//
// Each input item is parsed in the cycle it is accepted and its 0 to 3 results
// land in a small result buffer, which keeps them while the m_ side stalls.
// Otherwise one result leaves per cycle, so items with one result or none flow
// one per clock; one with more results holds s_tready low until one is left.
// aresetn (synchronous, active low) returns the parser to its start state.
module uri_origin_path_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data[7:0], error_code[10:8], zero fill
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast
);
    import uopd_pkg::*;

    step_out_t step_out;
    res_t      out_res;
    logic      take;

    assign take = s_tvalid && s_tready;

    uopd_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .byte_in    (s_tdata),
        .final_byte (s_tlast),
        .step_out   (step_out)
    );

    uopd_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .step_out  (step_out),
        .can_load  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.error_code, out_res.data};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.run_end;

endmodule

// ===== dv/uri_origin_path_decoder_tb.sv =====
module uri_origin_path_decoder_tb;
    import uopd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 300;

    typedef enum logic [2:0] {
        P_START,
        P_PATH,
        P_ESC_HI,
        P_ESC_LO,
        P_QUERY,
        P_SKIP
    } parse_phase_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } raw_char_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] code;
        logic       last;
    } decoded_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    raw_char_t raw_chars[$];
    decoded_t  decoded_tokens[$];
    decoded_t  step_results[$];

    int chars_queued = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;

    // Parser state mirrored on the testbench side.
    parse_phase_t parse_phase = P_START;
    logic         seg_open = 1'b0;
    logic         seg_seen = 1'b0;
    logic [3:0]   hi_nibble = 4'h0;

    uri_origin_path_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic bit is_path_char(input logic [7:0] c);
        unique case (c)
            "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=",
            ":", "@": begin
                return 1'b1;
            end
            default: begin
                return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                       (c >= "a" && c <= "z");
            end
        endcase
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end else if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end else if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end
        return -1;
    endfunction

    task automatic add_token(input logic [2:0] kind, input logic [7:0] data,
                             input logic [2:0] code);
        decoded_t t;
        t.kind = kind;
        t.data = data;
        t.code = code;
        t.last = 1'b0;
        step_results = {step_results, t};
    endtask

    // A bare "/" path closes no segment; anything longer closes the open one.
    task automatic close_open_path();
        if (seg_open || seg_seen) begin
            add_token(K_SEG_END, 8'h00, E_NONE);
        end
        seg_open = 1'b0;
        seg_seen = 1'b0;
    endtask

    task automatic reset_parser();
        parse_phase = P_START;
        seg_open = 1'b0;
        seg_seen = 1'b0;
        hi_nibble = 4'h0;
    endtask

    task automatic parse_target_byte(input logic [7:0] b, input logic fin);
        logic [2:0] err;
        int hex;
        decoded_t t;
        err = E_NONE;
        hex = hex_digit(b);
        step_results.delete();
        if (parse_phase == P_SKIP) begin
            if (fin) begin
                reset_parser();
            end
        end else begin
            case (parse_phase)
                P_PATH: begin
                    if (b == CH_SLASH) begin
                        if (seg_open) begin
                            add_token(K_SEG_END, 8'h00, E_NONE);
                            seg_open = 1'b0;
                            seg_seen = 1'b1;
                        end else begin
                            err = E_BAD_PATH;
                        end
                    end else if (b == CH_PCT) begin
                        parse_phase = P_ESC_HI;
                    end else if (b == CH_QMARK) begin
                        close_open_path();
                        add_token(K_QUERY_START, 8'h00, E_NONE);
                        parse_phase = P_QUERY;
                    end else if (is_path_char(b)) begin
                        add_token(K_PATH_BYTE, b, E_NONE);
                        seg_open = 1'b1;
                    end else begin
                        err = E_BAD_SEG;
                    end
                end
                P_ESC_HI: begin
                    if (hex >= 0) begin
                        hi_nibble = hex[3:0];
                        parse_phase = P_ESC_LO;
                    end else begin
                        err = E_BAD_ESCAPE;
                    end
                end
                P_ESC_LO: begin
                    if (hex >= 0) begin
                        add_token(K_PATH_BYTE, {hi_nibble, hex[3:0]}, E_NONE);
                        seg_open = 1'b1;
                        parse_phase = P_PATH;
                    end else begin
                        err = E_BAD_ESCAPE;
                    end
                end
                P_QUERY: begin
                    if (is_path_char(b) || b == CH_SLASH || b == CH_QMARK || b == CH_PCT) begin
                        add_token(K_QUERY_BYTE, b, E_NONE);
                    end else begin
                        err = E_BAD_QUERY;
                    end
                end
                default: begin
                    if (b == CH_SLASH) begin
                        parse_phase = P_PATH;
                    end else begin
                        err = E_BAD_PATH;
                    end
                end
            endcase

            if (err == E_NONE && fin) begin
                if (parse_phase == P_PATH) begin
                    close_open_path();
                    add_token(K_ACCEPT, 8'h00, E_NONE);
                end else if (parse_phase == P_QUERY) begin
                    add_token(K_ACCEPT, 8'h00, E_NONE);
                end else begin
                    // The target ended inside an escape.
                    err = E_BAD_ESCAPE;
                end
            end

            if (err != E_NONE) begin
                step_results.delete();
                add_token(K_ERROR, 8'h00, err);
                if (fin) begin
                    reset_parser();
                end else begin
                    parse_phase = P_SKIP;
                end
            end else if (fin) begin
                reset_parser();
            end

            foreach (step_results[i]) begin
                t = step_results[i];
                t.last = (i == step_results.size() - 1);
                decoded_tokens = {decoded_tokens, t};
            end
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic fin);
        raw_char_t r;
        r.ch = c;
        r.fin = fin;
        raw_chars = {raw_chars, r};
        chars_queued++;
    endtask

    task automatic push_text(input string s, input logic fin_at_end);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], fin_at_end && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] rand_path_char();
        string sym;
        int r;
        sym = "-._~!$&'()*+,;=:@";
        r = $urandom_range(0, 78);
        if (r < 10) begin
            return 8'("0" + r);
        end else if (r < 36) begin
            return 8'("A" + r - 10);
        end else if (r < 62) begin
            return 8'("a" + r - 36);
        end
        return sym[r - 62];
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'("0" + v);
        end else if ($urandom_range(0, 1) == 0) begin
            return 8'("A" + v - 10);
        end
        return 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] rand_query_char();
        unique case ($urandom_range(0, 9))
            0: return CH_SLASH;
            1: return CH_QMARK;
            2: return CH_PCT;
            default: return rand_path_char();
        endcase
    endfunction

    // Mostly well-formed targets with random content; the rest are noise,
    // targets with one byte replaced at random, and targets cut inside an escape.
    task automatic queue_random_target();
        logic [7:0] chars[$];
        int mode;
        int nseg;
        int pos;
        mode = $urandom_range(0, 99);
        if (mode < 8) begin
            repeat ($urandom_range(1, 4)) chars = {chars, 8'($urandom_range(0, 255))};
        end else begin
            chars = {chars, CH_SLASH};
            nseg = $urandom_range(0, 3);
            for (int s = 0; s < nseg; s++) begin
                if (s > 0) begin
                    chars = {chars, CH_SLASH};
                end
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        chars = {chars, CH_PCT};
                        chars = {chars, rand_hex_char()};
                        chars = {chars, rand_hex_char()};
                    end else begin
                        chars = {chars, rand_path_char()};
                    end
                end
            end
            if (nseg > 0 && $urandom_range(0, 2) == 0) begin
                chars = {chars, CH_SLASH};
            end
            if ($urandom_range(0, 2) == 0) begin
                chars = {chars, CH_QMARK};
                repeat ($urandom_range(0, 4)) chars = {chars, rand_query_char()};
            end
            if (mode < 22) begin
                pos = $urandom_range(0, chars.size() - 1);
                chars[pos] = 8'($urandom_range(0, 255));
            end else if (mode < 30) begin
                chars = {chars, CH_PCT};
                if ($urandom_range(0, 1) == 1) begin
                    chars = {chars, rand_hex_char()};
                end
            end
        end
        foreach (chars[i]) begin
            push_char(chars[i], i == chars.size() - 1);
        end
    endtask

    // Waits until every queued item went in and every result came out.
    task automatic drain();
        while (raw_chars.size() != 0 || s_tvalid) @(posedge aclk);
        while (decoded_tokens.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int n_items,
                             input bit long_hold);
        int first;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        if (long_hold) begin
            hold_request <= 1'b1;
        end
        first = chars_queued;
        while (chars_queued - first < n_items) queue_random_target();
        drain();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (raw_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= raw_chars[0].ch;
                s_tlast <= raw_chars[0].fin;
                raw_chars.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Results are checked before the item of the same edge is predicted, since
    // a result can leave no earlier than the cycle after its item went in.
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (decoded_tokens.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected: kind %0d tdata %h last %b",
                             $time, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = decoded_tokens.pop_front();
                    if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
                        m_tdata[10:8] !== want.code || m_tlast !== want.last ||
                        m_tdata[15:11] !== 5'b0) begin
                        mismatches++;
                        $display({"%0t: expected kind %0d data %h code %0d last %b,",
                                  " got kind %0d data %h code %0d last %b fill %b"},
                                 $time, want.kind, want.data, want.code, want.last,
                                 m_tuser, m_tdata[7:0], m_tdata[10:8], m_tlast,
                                 m_tdata[15:11]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_target_byte(s_tdata, s_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("uri_origin_path_decoder_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Bare root, a first byte that is not a slash, trailing slash,
        // empty inner segment, escape closing the path at '?'.
        push_text("/", 1'b1);
        push_text("?", 1'b1);
        push_text("/a/", 1'b1);
        push_text("//", 1'b1);
        push_text("/%4a?", 1'b1);
        // Bad hex digit, target ending inside an escape.
        push_text("/%g", 1'b1);
        push_text("/%4", 1'b1);
        // Illegal path byte, then bytes skipped up to the final one.
        push_char(CH_SLASH, 1'b0);
        push_char(8'h00, 1'b0);
        push_text("yz", 1'b1);
        // Unchecked escape in the query, then an illegal query byte.
        push_text("/?%z", 1'b0);
        push_char(8'hFF, 1'b1);
        drain();

        run_phase(0, 0, 26, 1'b0);
        run_phase(63, 0, 26, 1'b0);
        run_phase(0, 63, 26, 1'b0);
        run_phase(18, 18, 26, 1'b0);
        run_phase(0, 0, 26, 1'b1);

        if (mismatches == 0) begin
            $display("uri_origin_path_decoder_tb OK");
        end else begin
            $display("uri_origin_path_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
